// File: design/qtam_pkg.sv
package qtam_pkg;

  localparam int ByteW    = 40;
  localparam int LimitW   = 37;
  localparam int IvlW     = 16;
  localparam int PctW     = 7;
  localparam int WaitW    = 32;
  localparam int RateW    = 50;
  localparam int ScaledW  = 50;
  localparam int DivisorW = IvlW + LimitW;
  localparam int ThrW     = LimitW + PctW;
  localparam int ProdW    = RateW + PctW;
  localparam int DivCntW  = $clog2(ScaledW);
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = LimitW;
  localparam int StepW    = 4;

  localparam int MsPerSec    = 1000;
  localparam int PercentBase = 100;

  localparam logic [CfgIdxW-1:0] CfgUpLimit   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDownLimit = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgInterval  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgUpOn      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgUpOff     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDownOn    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgDownOff   = 3'd6;

  localparam logic [IvlW-1:0] IvlReset     = 16'd500;
  localparam logic [PctW-1:0] OnPctReset   = 7'd85;
  localparam logic [PctW-1:0] OffPctReset  = 7'd50;

  typedef logic [StepW-1:0] step_t;

  localparam step_t StepPrep    = 4'd0;
  localparam step_t StepLimMul  = 4'd1;
  localparam step_t StepLimDiv  = 4'd2;
  localparam step_t StepSetWait = 4'd3;
  localparam step_t StepRateMul = 4'd4;
  localparam step_t StepRateDiv = 4'd5;
  localparam step_t StepSetRate = 4'd6;
  localparam step_t StepThrMul  = 4'd7;
  localparam step_t StepAlarm   = 4'd8;
  localparam step_t StepOut     = 4'd9;

  typedef enum logic [2:0] {
    OpPrep,
    OpLimMul,
    OpDiv,
    OpSetWait,
    OpRateMul,
    OpSetRate,
    OpThrMul,
    OpAlarm
  } op_e;

  typedef enum logic [2:0] {
    CondNone,
    CondBytesZero,
    CondLimitZero,
    CondDirUp,
    CondHold
  } cond_e;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvRaise = 2'd1,
    EvClear = 2'd2
  } event_e;

  typedef struct packed {
    logic  is_out;
    op_e   op;
    cond_e cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic [ByteW-1:0] up_bytes;
    logic [ByteW-1:0] down_bytes;
  } meter_in_t;

  typedef struct packed {
    logic [RateW-1:0] up_rate;
    logic [RateW-1:0] down_rate;
    logic             up_alarm;
    logic             down_alarm;
    logic [1:0]       up_event;
    logic [1:0]       down_event;
  } meter_out_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t uc;
    uc = '{is_out: 1'b0, op: OpPrep, cond: CondNone, target: StepPrep};
    case (step)
      StepPrep:    uc = '{1'b0, OpPrep,    CondBytesZero, StepThrMul};
      StepLimMul:  uc = '{1'b0, OpLimMul,  CondLimitZero, StepRateMul};
      StepLimDiv:  uc = '{1'b0, OpDiv,     CondHold,      StepLimDiv};
      StepSetWait: uc = '{1'b0, OpSetWait, CondNone,      StepPrep};
      StepRateMul: uc = '{1'b0, OpRateMul, CondNone,      StepPrep};
      StepRateDiv: uc = '{1'b0, OpDiv,     CondHold,      StepRateDiv};
      StepSetRate: uc = '{1'b0, OpSetRate, CondNone,      StepPrep};
      StepThrMul:  uc = '{1'b0, OpThrMul,  CondNone,      StepPrep};
      StepAlarm:   uc = '{1'b0, OpAlarm,   CondDirUp,     StepPrep};
      default:     uc = '{1'b1, OpPrep,    CondHold,      StepOut};
    endcase
    return uc;
  endfunction

endpackage

// File: design/qos_throughput_alert_meter.sv
// Each direction runs up to two restoring divisions on the shared one-bit-per-cycle divider;
// the microcode sequencer takes one item at a time, and the next input is taken while a
// finished result waits in the output register.
// Reset: rst_ni is asynchronous and active low; it clears wait counts, held rates, alarms and
// control, and loads the configuration registers with their documented reset values.
module qos_throughput_alert_meter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  qtam_pkg::meter_in_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output qtam_pkg::meter_out_t            out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [qtam_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [qtam_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int ScaledW  = qtam_pkg::ScaledW;
  localparam int DivisorW = qtam_pkg::DivisorW;
  localparam int WaitW    = qtam_pkg::WaitW;
  localparam int RateW    = qtam_pkg::RateW;
  localparam int ThrW     = qtam_pkg::ThrW;
  localparam int ProdW    = qtam_pkg::ProdW;
  localparam int DivCntW  = qtam_pkg::DivCntW;
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(ScaledW - 1);

  logic [qtam_pkg::LimitW-1:0] up_limit_q, down_limit_q;
  logic [qtam_pkg::IvlW-1:0]   ivl_q;
  logic [qtam_pkg::PctW-1:0]   up_on_q, up_off_q, down_on_q, down_off_q;

  qtam_pkg::meter_in_t  in_q, in_d;
  qtam_pkg::meter_out_t out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic                 busy_q, busy_d;
  logic                 dir_q, dir_d;
  qtam_pkg::step_t      step_q, step_d;
  logic [DivCntW-1:0]   div_cnt_q, div_cnt_d;

  logic [WaitW-1:0]    wait_q [2];
  logic [WaitW-1:0]    wait_d [2];
  logic [RateW-1:0]    rate_q [2];
  logic [RateW-1:0]    rate_d [2];
  logic                alarm_q [2];
  logic                alarm_d [2];
  logic [1:0]          event_q [2];
  logic [1:0]          event_d [2];

  logic [ScaledW-1:0]  scaled_q, scaled_d;
  logic [ScaledW-1:0]  a_q, a_d;
  logic [DivisorW-1:0] b_q, b_d;
  logic [DivisorW-1:0] rem_q, rem_d;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [ThrW-1:0]     on_thr_q, on_thr_d;
  logic [ThrW-1:0]     off_thr_q, off_thr_d;

  qtam_pkg::ucode_t            uc;
  logic                        in_xfer;
  logic                        out_load;
  logic                        cond_hit;
  logic [qtam_pkg::ByteW-1:0]  sel_bytes;
  logic [qtam_pkg::LimitW-1:0] sel_limit;
  logic [qtam_pkg::PctW-1:0]   sel_on, sel_off;
  logic [qtam_pkg::IvlW-1:0]   ivl;
  logic [WaitW-1:0]            wait_dec;
  logic [DivisorW:0]           div_cand;
  logic                        div_ge;
  logic [ScaledW-1:0]          quot_m1;

  assign uc          = qtam_pkg::ucode_rom(step_q);
  assign in_ready_o  = !busy_q;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = busy_q && uc.is_out && (!out_valid_q || out_ready_i);

  assign sel_bytes = dir_q ? in_q.down_bytes : in_q.up_bytes;
  assign sel_limit = dir_q ? down_limit_q : up_limit_q;
  assign sel_on    = dir_q ? down_on_q : up_on_q;
  assign sel_off   = dir_q ? down_off_q : up_off_q;
  assign ivl       = (ivl_q == '0) ? qtam_pkg::IvlW'(1) : ivl_q;
  assign wait_dec  = (wait_q[dir_q] != '0) ? wait_q[dir_q] - WaitW'(1) : '0;
  assign div_cand  = {rem_q, a_q[ScaledW-1]};
  assign div_ge    = div_cand >= {1'b0, b_q};
  assign quot_m1   = (a_q != '0) ? a_q - ScaledW'(1) : '0;

  always_comb begin
    case (uc.cond)
      qtam_pkg::CondBytesZero: cond_hit = (sel_bytes == '0);
      qtam_pkg::CondLimitZero: cond_hit = (sel_limit == '0);
      qtam_pkg::CondDirUp:     cond_hit = !dir_q;
      default:                 cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    in_d        = in_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    busy_d      = busy_q;
    dir_d       = dir_q;
    step_d      = step_q;
    div_cnt_d   = div_cnt_q;
    wait_d      = wait_q;
    rate_d      = rate_q;
    alarm_d     = alarm_q;
    event_d     = event_q;
    scaled_d    = scaled_q;
    a_d         = a_q;
    b_d         = b_q;
    rem_d       = rem_q;
    prod_d      = prod_q;
    on_thr_d    = on_thr_q;
    off_thr_d   = off_thr_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (in_xfer) begin
      in_d   = in_data_i;
      busy_d = 1'b1;
      dir_d  = 1'b0;
      step_d = qtam_pkg::StepPrep;
    end else if (busy_q) begin
      if (uc.is_out) begin
        if (out_load) begin
          out_d.up_rate    = rate_q[0];
          out_d.down_rate  = rate_q[1];
          out_d.up_alarm   = alarm_q[0];
          out_d.down_alarm = alarm_q[1];
          out_d.up_event   = event_q[0];
          out_d.down_event = event_q[1];
          out_valid_d      = 1'b1;
          busy_d           = 1'b0;
          step_d           = qtam_pkg::StepPrep;
        end
      end else begin
        step_d = cond_hit ? uc.target : step_q + qtam_pkg::StepW'(1);
        case (uc.op)
          qtam_pkg::OpPrep: begin
            wait_d[dir_q]  = wait_dec;
            if (wait_dec == '0) begin
              rate_d[dir_q] = '0;
            end
            event_d[dir_q] = qtam_pkg::EvNone;
            scaled_d       = ScaledW'(sel_bytes) * ScaledW'(qtam_pkg::MsPerSec);
          end
          qtam_pkg::OpLimMul: begin
            a_d       = scaled_q;
            b_d       = DivisorW'(ivl) * DivisorW'(sel_limit);
            rem_d     = '0;
            div_cnt_d = '0;
          end
          qtam_pkg::OpDiv: begin
            a_d   = {a_q[ScaledW-2:0], div_ge};
            rem_d = div_ge ? DivisorW'(div_cand - {1'b0, b_q}) : div_cand[DivisorW-1:0];
            if (div_cnt_q == DivLast) begin
              step_d = step_q + qtam_pkg::StepW'(1);
            end else begin
              step_d    = step_q;
              div_cnt_d = div_cnt_q + DivCntW'(1);
            end
          end
          qtam_pkg::OpSetWait: begin
            wait_d[dir_q] = (quot_m1[ScaledW-1:WaitW] != '0) ? '1 : quot_m1[WaitW-1:0];
          end
          qtam_pkg::OpRateMul: begin
            a_d       = scaled_q;
            b_d       = DivisorW'(ivl) * DivisorW'({1'b0, wait_q[dir_q]} + (WaitW+1)'(1));
            rem_d     = '0;
            div_cnt_d = '0;
          end
          qtam_pkg::OpSetRate: begin
            rate_d[dir_q] = a_q[RateW-1:0];
          end
          qtam_pkg::OpThrMul: begin
            prod_d    = ProdW'(rate_q[dir_q]) * ProdW'(qtam_pkg::PercentBase);
            on_thr_d  = ThrW'(sel_limit) * ThrW'(sel_on);
            off_thr_d = ThrW'(sel_limit) * ThrW'(sel_off);
          end
          qtam_pkg::OpAlarm: begin
            if (!alarm_q[dir_q] && (prod_q > ProdW'(on_thr_q)) && (sel_limit != '0)) begin
              alarm_d[dir_q] = 1'b1;
              event_d[dir_q] = qtam_pkg::EvRaise;
            end else if (alarm_q[dir_q] &&
                         (prod_q + ProdW'(qtam_pkg::PercentBase) <= ProdW'(off_thr_q))) begin
              alarm_d[dir_q] = 1'b0;
              event_d[dir_q] = qtam_pkg::EvClear;
            end
            if (!dir_q) begin
              dir_d = 1'b1;
            end
          end
          default: begin
            step_d = qtam_pkg::StepOut;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_limit_q   <= '0;
      down_limit_q <= '0;
      ivl_q        <= qtam_pkg::IvlReset;
      up_on_q      <= qtam_pkg::OnPctReset;
      up_off_q     <= qtam_pkg::OffPctReset;
      down_on_q    <= qtam_pkg::OnPctReset;
      down_off_q   <= qtam_pkg::OffPctReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        qtam_pkg::CfgUpLimit:   up_limit_q   <= cfg_data_i;
        qtam_pkg::CfgDownLimit: down_limit_q <= cfg_data_i;
        qtam_pkg::CfgInterval:  ivl_q        <= cfg_data_i[qtam_pkg::IvlW-1:0];
        qtam_pkg::CfgUpOn:      up_on_q      <= cfg_data_i[qtam_pkg::PctW-1:0];
        qtam_pkg::CfgUpOff:     up_off_q     <= cfg_data_i[qtam_pkg::PctW-1:0];
        qtam_pkg::CfgDownOn:    down_on_q    <= cfg_data_i[qtam_pkg::PctW-1:0];
        qtam_pkg::CfgDownOff:   down_off_q   <= cfg_data_i[qtam_pkg::PctW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      dir_q       <= 1'b0;
      step_q      <= qtam_pkg::StepPrep;
      div_cnt_q   <= '0;
      wait_q      <= '{default: '0};
      rate_q      <= '{default: '0};
      alarm_q     <= '{default: 1'b0};
      event_q     <= '{default: qtam_pkg::EvNone};
    end else begin
      out_valid_q <= out_valid_d;
      busy_q      <= busy_d;
      dir_q       <= dir_d;
      step_q      <= step_d;
      div_cnt_q   <= div_cnt_d;
      wait_q      <= wait_d;
      rate_q      <= rate_d;
      alarm_q     <= alarm_d;
      event_q     <= event_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    out_q     <= out_d;
    scaled_q  <= scaled_d;
    a_q       <= a_d;
    b_q       <= b_d;
    rem_q     <= rem_d;
    prod_q    <= prod_d;
    on_thr_q  <= on_thr_d;
    off_thr_q <= off_thr_d;
  end

  // The partial remainder always stays below a nonzero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !uc.is_out && (uc.op == qtam_pkg::OpDiv) |-> (b_q != '0) && (rem_q < b_q))
    else $error("divider remainder out of range");

  // A result is only produced after both directions have been processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> dir_q)
    else $error("result produced before downstream pass");

  // An accepted transfer starts the program at its first step on the upstream side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> busy_q && !dir_q && (step_q == qtam_pkg::StepPrep))
    else $error("program did not start after input transfer");

  // The divide counter never runs past the dividend width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_cnt_q <= DivLast)
    else $error("divide counter overrun");

  // An upstream raise event always leaves the upstream alarm on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.up_event == qtam_pkg::EvRaise) |-> out_q.up_alarm)
    else $error("upstream raise without alarm");

endmodule

// File: tb/qos_throughput_alert_meter_tb.sv
`timescale 1ns / 1ps

module qos_throughput_alert_meter_tb;

  localparam int ByteW    = qtam_pkg::ByteW;
  localparam int LimitW   = qtam_pkg::LimitW;
  localparam int IvlW     = qtam_pkg::IvlW;
  localparam int PctW     = qtam_pkg::PctW;
  localparam int WaitW    = qtam_pkg::WaitW;
  localparam int RateW    = qtam_pkg::RateW;
  localparam int CfgIdxW  = qtam_pkg::CfgIdxW;
  localparam int CfgDataW = qtam_pkg::CfgDataW;

  localparam logic [CfgIdxW-1:0] CfgSpare = 3'd7;
  localparam logic [ByteW-1:0] ByteMax = '1;
  localparam logic [LimitW-1:0] LimitMax = '1;
  localparam logic [IvlW-1:0] IvlMax = '1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  qtam_pkg::meter_in_t  in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  qtam_pkg::meter_out_t out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  logic [LimitW-1:0] limit_reg [2];
  logic [PctW-1:0]   on_pct [2];
  logic [PctW-1:0]   off_pct [2];
  logic [IvlW-1:0]   ivl_reg;
  logic [WaitW-1:0]  wait_cnt [2];
  logic [RateW-1:0]  held_rate [2];
  logic              alarm_on [2];

  qtam_pkg::meter_out_t expected_ticks [$];
  qtam_pkg::meter_out_t want_tick;
  int unsigned mismatch_count = 0;
  bit steady_flow;

  qos_throughput_alert_meter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic qtam_pkg::event_e advance_direction(input int d,
                                                         input logic [ByteW-1:0] bytes);
    logic [63:0] ivl;
    logic [63:0] scaled;
    logic [63:0] quot;
    logic [63:0] on_thr;
    logic [63:0] off_thr;
    ivl = (ivl_reg == 0) ? 64'd1 : 64'(ivl_reg);
    if (wait_cnt[d] != 0) wait_cnt[d] = wait_cnt[d] - WaitW'(1);
    if (wait_cnt[d] == 0) held_rate[d] = '0;
    if (bytes != 0) begin
      scaled = 64'(bytes) * 64'(qtam_pkg::MsPerSec);
      if (limit_reg[d] != 0) begin
        quot = scaled / (ivl * 64'(limit_reg[d]));
        if (quot > 0) quot = quot - 64'd1;
        if (quot > 64'hFFFF_FFFF) quot = 64'hFFFF_FFFF;
        wait_cnt[d] = quot[WaitW-1:0];
      end
      quot = scaled / (ivl * (64'(wait_cnt[d]) + 64'd1));
      held_rate[d] = quot[RateW-1:0];
    end
    on_thr = 64'(limit_reg[d]) * 64'(on_pct[d]) / 64'(qtam_pkg::PercentBase);
    off_thr = 64'(limit_reg[d]) * 64'(off_pct[d]) / 64'(qtam_pkg::PercentBase);
    if (!alarm_on[d] && 64'(held_rate[d]) > on_thr && limit_reg[d] != 0) begin
      alarm_on[d] = 1'b1;
      return qtam_pkg::EvRaise;
    end
    if (alarm_on[d] && 64'(held_rate[d]) < off_thr) begin
      alarm_on[d] = 1'b0;
      return qtam_pkg::EvClear;
    end
    return qtam_pkg::EvNone;
  endfunction

  function automatic qtam_pkg::meter_out_t predict_tick(input logic [ByteW-1:0] up_b,
                                                        input logic [ByteW-1:0] down_b);
    qtam_pkg::meter_out_t res;
    res.up_event   = advance_direction(0, up_b);
    res.down_event = advance_direction(1, down_b);
    res.up_rate    = held_rate[0];
    res.down_rate  = held_rate[1];
    res.up_alarm   = alarm_on[0];
    res.down_alarm = alarm_on[1];
    return res;
  endfunction

  task automatic check_field(input string what, input logic [RateW-1:0] want,
                             input logic [RateW-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch in %s: expected %0d, got %0d", what, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_ticks.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result transfer with nothing expected");
      end else begin
        want_tick = expected_ticks.pop_front();
        check_field("up_rate", want_tick.up_rate, out_data_o.up_rate);
        check_field("down_rate", want_tick.down_rate, out_data_o.down_rate);
        check_field("up_alarm", RateW'(want_tick.up_alarm), RateW'(out_data_o.up_alarm));
        check_field("down_alarm", RateW'(want_tick.down_alarm), RateW'(out_data_o.down_alarm));
        check_field("up_event", RateW'(want_tick.up_event), RateW'(out_data_o.up_event));
        check_field("down_event", RateW'(want_tick.down_event), RateW'(out_data_o.down_event));
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i = steady_flow || ($urandom_range(99) >= 10);
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      qtam_pkg::CfgUpLimit:   limit_reg[0] = data[LimitW-1:0];
      qtam_pkg::CfgDownLimit: limit_reg[1] = data[LimitW-1:0];
      qtam_pkg::CfgInterval:  ivl_reg = data[IvlW-1:0];
      qtam_pkg::CfgUpOn:      on_pct[0] = data[PctW-1:0];
      qtam_pkg::CfgUpOff:     off_pct[0] = data[PctW-1:0];
      qtam_pkg::CfgDownOn:    on_pct[1] = data[PctW-1:0];
      qtam_pkg::CfgDownOff:   off_pct[1] = data[PctW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_tick(input logic [ByteW-1:0] up_b, input logic [ByteW-1:0] down_b);
    @(negedge clk_i);
    if (!steady_flow && $urandom_range(99) < 10) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk_i);
    end
    in_data_i  = '{up_bytes: up_b, down_bytes: down_b};
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_ticks.insert(expected_ticks.size(), predict_tick(up_b, down_b));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [CfgDataW-1:0] with_junk(input logic [CfgDataW-1:0] value,
                                                    input int width);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'({$urandom(), $urandom()});
    if ($urandom_range(3) == 0) return (junk << width) | value;
    return value;
  endfunction

  function automatic logic [LimitW-1:0] pick_limit();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return LimitW'(1);
    if (roll == 2) return LimitMax;
    if (roll < 6) return LimitW'($urandom_range(1, 100000));
    return LimitW'({$urandom(), $urandom()});
  endfunction

  function automatic logic [IvlW-1:0] pick_interval();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return IvlW'(1);
    if (roll == 2) return IvlMax;
    if (roll == 3) return IvlW'($urandom());
    return IvlW'($urandom_range(1, 2000));
  endfunction

  function automatic logic [PctW-1:0] pick_percent();
    int unsigned roll;
    roll = $urandom_range(11);
    if (roll == 0) return '0;
    if (roll == 1) return PctW'(127);
    if (roll == 2) return PctW'(100);
    if (roll == 3) return PctW'(1);
    if (roll == 4) return PctW'($urandom());
    return PctW'($urandom_range(1, 100));
  endfunction

  function automatic logic [ByteW-1:0] pick_bytes(input int d);
    logic [63:0] nominal;
    logic [63:0] ivl;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return '0;
    if (roll < 25) return ByteW'({$urandom(), $urandom()});
    if (roll < 30) return ByteW'($urandom_range(1, 1000));
    ivl = (ivl_reg == 0) ? 64'd1 : 64'(ivl_reg);
    if (limit_reg[d] == 0) begin
      nominal = 64'($urandom_range(1, 1 << 24));
    end else begin
      nominal = 64'(limit_reg[d]) * ivl / 64'(qtam_pkg::MsPerSec);
    end
    nominal = nominal * 64'($urandom_range(0, 300)) / 64'd100;
    if (nominal > 64'(ByteMax)) nominal = 64'(ByteMax);
    return nominal[ByteW-1:0];
  endfunction

  task automatic randomize_settings();
    write_reg(qtam_pkg::CfgUpLimit, pick_limit());
    write_reg(qtam_pkg::CfgDownLimit, pick_limit());
    write_reg(qtam_pkg::CfgInterval, with_junk(CfgDataW'(pick_interval()), IvlW));
    write_reg(qtam_pkg::CfgUpOn, with_junk(CfgDataW'(pick_percent()), PctW));
    write_reg(qtam_pkg::CfgUpOff, with_junk(CfgDataW'(pick_percent()), PctW));
    write_reg(qtam_pkg::CfgDownOn, with_junk(CfgDataW'(pick_percent()), PctW));
    write_reg(qtam_pkg::CfgDownOff, with_junk(CfgDataW'(pick_percent()), PctW));
    if ($urandom_range(9) < 3) write_reg(CfgSpare, CfgDataW'({$urandom(), $urandom()}));
  endtask

  task automatic test_reset_values();
    send_tick('0, '0);
    send_tick(ByteMax, ByteMax);
    send_tick(ByteW'(1), ByteW'(1000));
  endtask

  task automatic test_wait_countdown();
    wait_idle();
    write_reg(qtam_pkg::CfgUpLimit, CfgDataW'(100));
    write_reg(qtam_pkg::CfgDownLimit, CfgDataW'(250));
    write_reg(qtam_pkg::CfgInterval, CfgDataW'(1000));
    send_tick(ByteW'(400), ByteW'(2000));
    repeat (3) send_tick('0, '0);
  endtask

  task automatic test_zero_limit_alarm();
    send_tick(ByteW'(400), '0);
    wait_idle();
    write_reg(qtam_pkg::CfgUpLimit, CfgDataW'(0));
    repeat (3) send_tick('0, '0);
    wait_idle();
    write_reg(qtam_pkg::CfgUpLimit, CfgDataW'(100));
    send_tick('0, '0);
  endtask

  task automatic test_extremes();
    wait_idle();
    write_reg(qtam_pkg::CfgInterval, CfgDataW'(0));
    write_reg(qtam_pkg::CfgUpLimit, CfgDataW'(1));
    write_reg(qtam_pkg::CfgDownLimit, CfgDataW'(LimitMax));
    write_reg(qtam_pkg::CfgUpOn, CfgDataW'(0));
    write_reg(qtam_pkg::CfgUpOff, CfgDataW'(127));
    write_reg(qtam_pkg::CfgDownOn, CfgDataW'(127));
    write_reg(qtam_pkg::CfgDownOff, CfgDataW'(100));
    send_tick(ByteMax, ByteMax);
    send_tick(ByteW'(1), ByteW'(1));
    wait_idle();
    write_reg(qtam_pkg::CfgInterval, CfgDataW'(IvlMax));
    send_tick(ByteMax, ByteMax);
    send_tick('0, ByteMax);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 12; phase++) begin
      wait_idle();
      randomize_settings();
      steady_flow = (phase == 4);
      for (int n = 0; n < 54; n++) send_tick(pick_bytes(0), pick_bytes(1));
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = qtam_pkg::CfgUpLimit;
    cfg_data_i  = '0;
    steady_flow = 1'b0;
    for (int d = 0; d < 2; d++) begin
      limit_reg[d] = '0;
      on_pct[d]    = qtam_pkg::OnPctReset;
      off_pct[d]   = qtam_pkg::OffPctReset;
      wait_cnt[d]  = '0;
      held_rate[d] = '0;
      alarm_on[d]  = 1'b0;
    end
    ivl_reg = qtam_pkg::IvlReset;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_wait_countdown();
    test_zero_limit_alarm();
    test_extremes();
    test_random_traffic();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
